### src/sp2c_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the scan point converter.
`default_nettype none

package sp2c_pkg;

  // Field widths of the streams and registers.
  localparam int unsigned IdxW    = 12;
  localparam int unsigned RangeW  = 16;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned CoordW  = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // Samples at or beyond this index are dropped.
  localparam int unsigned ScanPoints = 4096;

  // CORDIC datapath: 12 fraction bits on x and y, 2^32 phase units per turn.
  localparam int unsigned CordicIters = 24;
  localparam int unsigned FracBits    = 12;
  localparam int unsigned XyW         = 31;
  localparam int unsigned ZW          = 32;

  // Gain correction, 1/1.64676 in Q16, then round and drop 28 bits.
  localparam int          GainQ16  = 39797;
  localparam int unsigned GainW    = 17;
  localparam int unsigned ProdW    = XyW + GainW;
  localparam int unsigned RoundSh  = 28;
  localparam int unsigned RndW     = ProdW - RoundSh;
  localparam int          CoordMax = 65535;
  localparam int          CoordMin = -65536;

  // Queue between the front and the back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgAngleStart = 2'd0,
    CfgAngleStep  = 2'd1,
    CfgNearThr    = 2'd2
  } cfg_idx_e;

  // One classified sample on its way to the CORDIC.
  typedef struct packed {
    logic [RangeW-1:0]        range;
    logic signed [AngleW-1:0] phase;
    logic                     flip;
    logic                     near;
  } work_t;

  // Occupancy of the queue.
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } q_stat_t;

  // Arctangent of 2^-i in 2^32 units per turn.
  function automatic logic [ZW-1:0] atan_at(input int unsigned i);
    logic [ZW-1:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### src/sp2c_front.sv
// Front end: configuration registers, sample filtering, angle and near flag.
`default_nettype none

module sp2c_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration writes.
  input  wire logic                           cfg_we_i,
  input  wire logic [sp2c_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sp2c_pkg::CfgW-1:0]      cfg_data_i,
  // Incoming samples.
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [sp2c_pkg::IdxW-1:0]      idx_i,
  input  wire logic [sp2c_pkg::RangeW-1:0]    range_i,
  input  wire logic                           range_valid_i,
  // Classified items toward the queue.
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output sp2c_pkg::work_t                     out_item_o
);
  import sp2c_pkg::*;

  logic [AngleW-1:0]     start_q, step_q, thr_q;
  logic [IdxW+AngleW-1:0] prod;
  logic [AngleW-1:0]     ang;
  logic                  flip;
  logic                  keep;
  logic                  vld_q;
  work_t                 item_d, item_q;

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 16'h8000;
      step_q  <= 16'd16;
      thr_q   <= 16'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgAngleStart: start_q <= cfg_data_i;
        CfgAngleStep:  step_q  <= cfg_data_i;
        CfgNearThr:    thr_q   <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Sample angle, wrapped to 16 bits, folded into the right half plane.
  always_comb begin
    prod = idx_i * step_q;
    ang  = start_q + prod[AngleW-1:0];
    flip = ang[AngleW-1] ^ ang[AngleW-2];
    keep = range_valid_i && ({1'b0, idx_i} < (IdxW+1)'(ScanPoints));
    item_d.range = range_i;
    item_d.phase = {ang[AngleW-1] ^ flip, ang[AngleW-2:0]};
    item_d.flip  = flip;
    item_d.near  = range_i < thr_q;
  end

  assign in_ready_o = !vld_q || out_ready_i;

  // Output register; dropped samples never enter it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

### src/sp2c_queue.sv
// Short item queue that lets the front and the back stall independently.
`default_nettype none

module sp2c_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire sp2c_pkg::work_t in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output sp2c_pkg::work_t  out_item_o,
  output sp2c_pkg::q_stat_t stat_o
);
  import sp2c_pkg::*;

  work_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign stat_o.full  = cnt_q == QCntW'(QDepth);
  assign stat_o.empty = cnt_q == '0;
  assign stat_o.count = cnt_q;

  assign in_ready_o  = !stat_o.full;
  assign out_valid_o = !stat_o.empty;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

endmodule

`default_nettype wire

### src/sp2c_back.sv
// Back end: pipelined CORDIC rotation, gain correction, rounding and saturation.
`default_nettype none

module sp2c_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire sp2c_pkg::work_t              in_item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [sp2c_pkg::CoordW-1:0]       x_o,
  output logic [sp2c_pkg::CoordW-1:0]       y_o,
  output logic                              near_o
);
  import sp2c_pkg::*;

  localparam int unsigned NStg = CordicIters + 1;
  localparam logic signed [GainW-1:0] Gain = GainW'(GainQ16);
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(1) << (RoundSh - 1);

  logic                    en;
  logic                    vld_q  [NStg];
  logic signed [XyW-1:0]   x_q    [NStg];
  logic signed [XyW-1:0]   y_q    [NStg];
  logic signed [ZW-1:0]    z_q    [NStg];
  logic                    flip_q [NStg];
  logic                    near_q [NStg];

  logic                    mv_q, mnear_q;
  logic signed [ProdW-1:0] px_q, py_q;
  logic signed [XyW-1:0]   xs, ys;
  logic signed [ProdW-1:0] rx_full, ry_full;
  logic signed [RndW-1:0]  rx, ry;

  logic                    ov_q, onear_q;
  logic [CoordW-1:0]       ox_q, oy_q;

  // The whole pipe moves unless a finished item waits at the output.
  assign en         = !ov_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 0 loads the start vector.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0]    <= XyW'({in_item_i.range, {FracBits{1'b0}}});
      y_q[0]    <= '0;
      z_q[0]    <= {in_item_i.phase, 16'b0};
      flip_q[0] <= in_item_i.flip;
      near_q[0] <= in_item_i.near;
    end
  end

  // One CORDIC micro-rotation per stage.
  for (genvar i = 0; i < CordicIters; i++) begin : g_iter
    logic signed [XyW-1:0] dx, dy;
    logic                  pos;

    assign dx  = y_q[i] >>> i;
    assign dy  = x_q[i] >>> i;
    assign pos = !z_q[i][ZW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        x_q[i+1]    <= pos ? x_q[i] - dx : x_q[i] + dx;
        y_q[i+1]    <= pos ? y_q[i] + dy : y_q[i] - dy;
        z_q[i+1]    <= pos ? z_q[i] - signed'(atan_at(i)) : z_q[i] + signed'(atan_at(i));
        flip_q[i+1] <= flip_q[i];
        near_q[i+1] <= near_q[i];
      end
    end
  end

  // Undo the half-turn fold and apply the gain correction.
  assign xs = flip_q[NStg-1] ? -x_q[NStg-1] : x_q[NStg-1];
  assign ys = flip_q[NStg-1] ? -y_q[NStg-1] : y_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en) begin
      mv_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q    <= ProdW'(xs) * ProdW'(Gain);
      py_q    <= ProdW'(ys) * ProdW'(Gain);
      mnear_q <= near_q[NStg-1];
    end
  end

  // Round to the nearest unit and clamp to the coordinate range.
  assign rx_full = (px_q + RoundHalf) >>> RoundSh;
  assign ry_full = (py_q + RoundHalf) >>> RoundSh;
  assign rx      = rx_full[RndW-1:0];
  assign ry      = ry_full[RndW-1:0];

  function automatic logic [CoordW-1:0] clamp(input logic signed [RndW-1:0] v);
    logic [CoordW-1:0] r;
    if (v > RndW'(CoordMax)) begin
      r = CoordW'(CoordMax);
    end else if (v < RndW'(CoordMin)) begin
      r = CoordW'(CoordMin);
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q    <= clamp(rx);
      oy_q    <= clamp(ry);
      onear_q <= mnear_q;
    end
  end

  assign out_valid_o = ov_q;
  assign x_o         = ox_q;
  assign y_o         = oy_q;
  assign near_o      = onear_q;

endmodule

`default_nettype wire

### src/scan_polar_to_cartesian.sv
// Top level of the laser scan sample to planar point converter.
`default_nettype none

// Each accepted sample with a finite range and an index inside the scan becomes one point:
// the angle start + index * step (16-bit binary angle, wrapping) is folded into the right
// half plane and fed to a 24-stage pipelined CORDIC, whose x and y are gain corrected,
// rounded and clamped to 17 bits; the near flag marks ranges below the threshold. One item
// is taken every clock cycle unless a front item is held back by a full queue. A point
// passes from the front register through the queue, the CORDIC load stage, the 24 rotation
// stages, the gain multiplier and the output register. A four-item queue sits between the
// front and the CORDIC pipe, which stalls as a whole only while a finished point waits at
// the output. Samples marked non-finite produce no point. The user is to write the
// configuration registers only while the block is idle; the block itself does not enforce this.
module scan_polar_to_cartesian (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [sp2c_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sp2c_pkg::CfgW-1:0]     cfg_data_i,
  // Sample stream.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,  // sample_index, range_mm, zero pad
  input  wire logic                          s_axis_tuser,  // range_valid
  // Point stream.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [39:0]                        m_axis_tdata,  // point_x, point_y, zero pad
  output logic                               m_axis_tuser   // near
);
  import sp2c_pkg::*;

  logic          f_valid, f_ready;
  work_t         f_item;
  logic          q_valid, b_ready;
  work_t         q_item;
  q_stat_t       q_stat;
  logic [CoordW-1:0] px, py;

  sp2c_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .idx_i         (s_axis_tdata[IdxW-1:0]),
    .range_i       (s_axis_tdata[IdxW+RangeW-1:IdxW]),
    .range_valid_i (s_axis_tuser),
    .out_valid_o   (f_valid),
    .out_ready_i   (f_ready),
    .out_item_o    (f_item)
  );

  sp2c_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_item_i   (f_item),
    .out_valid_o (q_valid),
    .out_ready_i (b_ready),
    .out_item_o  (q_item),
    .stat_o      (q_stat)
  );

  sp2c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (b_ready),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .x_o         (px),
    .y_o         (py),
    .near_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {6'b0, py, px};

`ifndef SYNTH
  // The fill count never passes the queue depth.
  a_q_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCntW'(QDepth))
    else $error("queue count beyond depth");

  // Full and empty are never flagged together.
  a_q_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  // While a point waits at the output, the CORDIC pipe takes nothing from the queue.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !(q_valid && b_ready))
    else $error("queue popped during output stall");

  // A full queue leaves the front holding its item.
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.full && f_valid && !(q_valid && b_ready)) |=> f_valid)
    else $error("front item lost while queue full");
`endif

endmodule

`default_nettype wire

### tb/sv/scan_point_checker.sv
// Checker of the scan point converter: predicts each point and compares it with the output.
`timescale 1ns / 100ps

module scan_point_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  import sp2c_pkg::*;

  localparam int  Stages     = 24;
  localparam longint GainQ16 = 39797;
  localparam longint CoordHi = 65535;
  localparam longint CoordLo = -65536;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic               near;
  } point_t;

  // Arctangent of 2^-i, 2^32 units per turn.
  longint atan_units [Stages] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // Mirror of the configuration registers.
  logic [15:0] start_angle;
  logic [15:0] step_angle;
  logic [15:0] near_limit;

  point_t expected_points [$];

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  // Gain correction, rounding and clamping of one CORDIC coordinate.
  function automatic logic signed [16:0] scale_coord(input longint v);
    longint r;
    r = (v * GainQ16 + (longint'(1) <<< 27)) >>> 28;
    if (r > CoordHi) r = CoordHi;
    if (r < CoordLo) r = CoordLo;
    return r[16:0];
  endfunction

  // Point of one valid sample under the current registers.
  function automatic point_t cordic_point(input logic [11:0] idx, input logic [15:0] rng);
    logic [15:0]        ang;
    logic               flip;
    logic signed [15:0] phase;
    longint             x, y, z, dx, dy;
    point_t             p;
    ang  = start_angle + idx * step_angle;
    flip = (ang >= 16'h4000) && (ang < 16'hC000);
    // Left half plane: rotate by half a turn and negate the result.
    if (flip) ang = ang + 16'h8000;
    phase = ang;
    x = longint'(rng);
    x = x * 4096;
    y = 0;
    z = longint'(phase);
    z = z * 65536;
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_units[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_units[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    p.x    = scale_coord(x);
    p.y    = scale_coord(y);
    p.near = rng < near_limit;
    return p;
  endfunction

  // Watch the configuration port and both streams.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t             want;
    logic signed [16:0] got_x;
    logic signed [16:0] got_y;
    if (!rst_ni) begin
      start_angle = 16'h8000;
      step_angle  = 16'd16;
      near_limit  = 16'd1024;
      expected_points.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgAngleStart: start_angle = cfg_data_i;
          CfgAngleStep:  step_angle  = cfg_data_i;
          CfgNearThr:    near_limit  = cfg_data_i;
          default: ;
        endcase
      end
      // Samples that are dropped or lie beyond the scan give no point.
      if (s_tvalid_i && s_tready_i && s_tuser_i && (s_tdata_i[11:0] < ScanPoints)) begin
        expected_points.insert(expected_points.size(),
                               cordic_point(s_tdata_i[11:0], s_tdata_i[27:12]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got_x = m_tdata_i[16:0];
        got_y = m_tdata_i[33:17];
        if (expected_points.size() == 0) begin
          $error("unexpected point: x %0d, y %0d, near %0b", got_x, got_y, m_tuser_i);
          mismatch_count_o++;
        end else begin
          want = expected_points.pop_front();
          if (got_x !== want.x) begin
            $error("point_x mismatch: expected %0d, got %0d", want.x, got_x);
            mismatch_count_o++;
          end
          if (got_y !== want.y) begin
            $error("point_y mismatch: expected %0d, got %0d", want.y, got_y);
            mismatch_count_o++;
          end
          if (m_tuser_i !== want.near) begin
            $error("near mismatch: expected %0b, got %0b", want.near, m_tuser_i);
            mismatch_count_o++;
          end
        end
      end
    end
    pending_o = expected_points.size();
  end

endmodule

### tb/sv/tb_top.sv
// Top of the scan point converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

  import sp2c_pkg::*;

  localparam logic [1:0] CfgUnusedIdx = 2'd3;
  localparam int PhaseItems  = 218;
  localparam int Phases      = 8;
  localparam int DrainCycles = 40;
  localparam int LongHold    = 300;
  localparam int StallLimit  = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  int mismatch_count;
  int pending;

  // Idle rates of both sides and the one long output hold.
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic long_hold_go;
  logic long_hold_done;
  logic [15:0] cur_thr;

  scan_polar_to_cartesian u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  scan_point_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : point_sink
    int hold_cnt;
    hold_cnt       = 0;
    long_hold_done = 1'b0;
    m_axis_tready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_cnt       = LongHold - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        hold_cnt = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Ends the run when no item moves on either side for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Offers one sample, after a random gap, and waits until it is taken.
  task automatic send_sample(input logic [11:0] idx, input logic [15:0] rng,
                             input logic finite);
    int gap;
    gap = 0;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
      gap = $urandom_range(1, 16);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, rng, idx};
    s_axis_tuser  <= finite;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering, waits for every point and then lets the pipe run idle before returning.
  task automatic drain_block();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Ranges weighted toward zero, full scale and the near threshold.
  function automatic logic [15:0] pick_range();
    int r;
    case ($urandom_range(0, 5))
      0: r = $urandom_range(0, 2047);
      1: begin
        r = int'(cur_thr) + $urandom_range(0, 3) - 2;
        if (r < 0) r = 0;
        if (r > 65535) r = 65535;
      end
      2: r = 65535 - $urandom_range(0, 15);
      3: r = $urandom_range(0, 15);
      default: r = $urandom_range(0, 65535);
    endcase
    return r[15:0];
  endfunction

  function automatic logic [11:0] pick_index();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd4095;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin : stimulus
    int          n_valid;
    logic [15:0] start_val, step_val;
    logic        finite;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgAngleStart;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    long_hold_go  = 1'b0;
    tx_idle_pct   = 20;
    rx_idle_pct   = 20;
    cur_thr       = 16'd1024;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset registers: angle 0x8000 + index * 16 reaches every quadrant edge and wraps.
    send_sample(12'd0,    16'd0,     1'b1);
    send_sample(12'd0,    16'd65535, 1'b1);
    send_sample(12'd1024, 16'd65535, 1'b1);
    send_sample(12'd1023, 16'd65535, 1'b1);
    send_sample(12'd2048, 16'd65535, 1'b1);
    send_sample(12'd3071, 16'd1000,  1'b1);
    send_sample(12'd3072, 16'd1023,  1'b1);
    send_sample(12'd3072, 16'd1024,  1'b1);
    send_sample(12'd4095, 16'd65535, 1'b1);
    send_sample(12'd4095, 16'd12345, 1'b0);
    send_sample(12'd1536, 16'd40000, 1'b1);
    send_sample(12'd2560, 16'd65535, 1'b1);
    send_sample(12'd0,    16'd0,     1'b0);
    send_sample(12'd2047, 16'd1,     1'b1);
    drain_block();

    // Random phases, each under its own register setting.
    for (int p = 1; p <= Phases; p++) begin
      start_val = 16'($urandom_range(0, 65535));
      step_val  = 16'($urandom_range(0, 65535));
      cur_thr   = 16'($urandom_range(0, 65535));
      case (p)
        1: begin
          start_val = 16'h0000;
          step_val  = 16'd1;
          cur_thr   = 16'd0;
        end
        2: begin
          start_val = 16'h7FFF;
          step_val  = 16'hFFFF;
          cur_thr   = 16'hFFFF;
        end
        3: begin
          start_val = 16'h8000;
          step_val  = 16'd0;
        end
        5: step_val = 16'($urandom_range(0, 64));
        default: ;
      endcase
      write_reg(CfgAngleStart, start_val);
      write_reg(CfgAngleStep,  step_val);
      write_reg(CfgNearThr,    cur_thr);
      // A write to the unused index must leave every register alone.
      if (p == 1) write_reg(CfgUnusedIdx, 16'hFFFF);
      if (p == 4 || p == Phases) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = $urandom_range(5, 40);
        rx_idle_pct = $urandom_range(5, 40);
      end
      if (p == 2) long_hold_go = 1'b1;
      n_valid = 0;
      while (n_valid < PhaseItems) begin
        finite = $urandom_range(0, 9) != 0;
        send_sample(pick_index(), pick_range(), finite);
        if (finite) n_valid++;
      end
      drain_block();
    end

    if (mismatch_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
src/sp2c_pkg.sv
src/sp2c_front.sv
src/sp2c_queue.sv
src/sp2c_back.sv
src/scan_polar_to_cartesian.sv
tb/sv/scan_point_checker.sv
tb/sv/tb_top.sv
